// ===== hdl/assert_macros.svh =====
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside reset
`define BSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define BSE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/bse_pkg.sv =====
`timescale 1ns / 1ps

package bse_pkg;

  localparam int MAX_ITEMS_DEF   = 64;
  localparam int NUM_BUCKETS_DEF = 16;
  localparam int BUCKET_CAP_DEF  = 16;
  localparam logic [15:0] WIDTH_RESET = 16'd10;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_DIST_RD,
    ST_DIST_INIT,
    ST_DIST_DIV,
    ST_DIST_PUT,
    ST_RK_CHECK,
    ST_RK_LATCH,
    ST_RK_IN_RD,
    ST_RK_IN_CMP,
    ST_RK_WR,
    ST_EM_RD,
    ST_EM_SHOW
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic sort_start;
    logic dist_rd;
    logic dist_init;
    logic dist_step;
    logic dist_put;
    logic ptr_clr;
    logic rk_outer_rd;
    logic rk_latch;
    logic rk_in_rd;
    logic rk_in_cmp;
    logic rk_wr;
    logic em_rd;
    logic em_pop;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic a_eq_cnt;
    logic a_eq_kc;
    logic b_eq_kc;
    logic div_last;
  } status_t;

endpackage

// ===== hdl/bse_ctrl.sv =====
`timescale 1ns / 1ps

module bse_ctrl
  import bse_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_axis_tvalid,
  input  logic    s_axis_tlast,
  output logic    s_axis_tready,
  input  logic    m_axis_tready,
  output logic    m_axis_tvalid,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (s_axis_tvalid && s_axis_tlast) state_next = ST_DIST_RD;
      end
      ST_DIST_RD: begin
        state_next = status.a_eq_cnt ? ST_RK_CHECK : ST_DIST_INIT;
      end
      ST_DIST_INIT: state_next = ST_DIST_DIV;
      ST_DIST_DIV: begin
        if (status.div_last) state_next = ST_DIST_PUT;
      end
      ST_DIST_PUT: state_next = ST_DIST_RD;
      ST_RK_CHECK: begin
        state_next = status.a_eq_kc ? ST_EM_RD : ST_RK_LATCH;
      end
      ST_RK_LATCH: state_next = ST_RK_IN_RD;
      ST_RK_IN_RD: begin
        state_next = status.b_eq_kc ? ST_RK_WR : ST_RK_IN_CMP;
      end
      ST_RK_IN_CMP: state_next = ST_RK_IN_RD;
      ST_RK_WR: state_next = ST_RK_CHECK;
      ST_EM_RD: begin
        state_next = status.a_eq_kc ? ST_LOAD : ST_EM_SHOW;
      end
      ST_EM_SHOW: begin
        if (m_axis_tready) state_next = ST_EM_RD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    cmd           = '0;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    case (state)
      ST_LOAD: begin
        s_axis_tready  = 1'b1;
        cmd.take       = s_axis_tvalid;
        cmd.sort_start = s_axis_tvalid && s_axis_tlast;
      end
      ST_DIST_RD: begin
        cmd.ptr_clr = status.a_eq_cnt;
        cmd.dist_rd = !status.a_eq_cnt;
      end
      ST_DIST_INIT: cmd.dist_init = 1'b1;
      ST_DIST_DIV:  cmd.dist_step = 1'b1;
      ST_DIST_PUT:  cmd.dist_put  = 1'b1;
      ST_RK_CHECK: begin
        cmd.ptr_clr     = status.a_eq_kc;
        cmd.rk_outer_rd = !status.a_eq_kc;
      end
      ST_RK_LATCH: cmd.rk_latch = 1'b1;
      ST_RK_IN_RD: cmd.rk_in_rd = !status.b_eq_kc;
      ST_RK_IN_CMP: cmd.rk_in_cmp = 1'b1;
      ST_RK_WR: cmd.rk_wr = 1'b1;
      ST_EM_RD: begin
        cmd.finish = status.a_eq_kc;
        cmd.em_rd  = !status.a_eq_kc;
      end
      ST_EM_SHOW: begin
        m_axis_tvalid = 1'b1;
        cmd.em_pop    = m_axis_tready;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== hdl/bse_datapath.sv =====
`timescale 1ns / 1ps

module bse_datapath
  import bse_pkg::*;
#(
  parameter int MAX_ITEMS       = MAX_ITEMS_DEF,
  parameter int NUM_BUCKETS     = NUM_BUCKETS_DEF,
  parameter int BUCKET_CAPACITY = BUCKET_CAP_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  input  logic signed [31:0] in_value,
  input  cmd_t               cmd,
  output status_t            status,
  output logic signed [31:0] out_value,
  output logic               out_last,
  output logic               out_dropped
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int QB = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int FW = $clog2(BUCKET_CAPACITY + 1);
  localparam int DW = 16 + QB;
  localparam int LW = 16 + $clog2(NUM_BUCKETS + 1) + 1;
  localparam logic [QB-1:0] BID_MAX = QB'(NUM_BUCKETS - 1);
  localparam logic [FW-1:0] CAP     = FW'(BUCKET_CAPACITY);
  localparam logic [CW-1:0] MAXC    = CW'(MAX_ITEMS);

  logic signed [31:0] load_mem [MAX_ITEMS];
  logic signed [31:0] kept_mem [MAX_ITEMS];
  logic signed [31:0] out_mem  [MAX_ITEMS];

  logic [15:0]        width_reg;
  logic [CW-1:0]      cnt, kc, ptr_a, ptr_b, rank;
  logic signed [31:0] run_min;
  logic               drop;
  logic [FW-1:0]      fill [NUM_BUCKETS];
  logic signed [31:0] load_rd, kept_rd, out_rd, x, outer;
  logic [31:0]        rem;
  logic [DW-1:0]      dsh;
  logic [QB-1:0]      q, step;
  logic               clamp;

  logic [15:0]   w_eff;
  logic [LW-1:0] limit;
  logic [31:0]   diff;
  logic          ge;
  logic [QB:0]   q_shift;
  logic [QB-1:0] bidx;
  logic          bucket_full;
  logic          less;
  logic [AW-1:0] kept_raddr;

  // divisor and clamp bound
  assign w_eff   = (width_reg == 16'd0) ? 16'd1 : width_reg;
  assign limit   = LW'(w_eff) * LW'(NUM_BUCKETS);
  assign diff    = 32'(load_rd) - 32'(run_min);
  assign ge      = rem >= 32'(dsh);
  assign q_shift = {q, ge};
  assign bidx    = clamp ? BID_MAX : q;
  assign bucket_full = fill[bidx] >= CAP;
  assign less = (kept_rd < outer) || ((kept_rd == outer) && (ptr_b < ptr_a));
  assign kept_raddr = cmd.rk_outer_rd ? ptr_a[AW-1:0] : ptr_b[AW-1:0];

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg <= WIDTH_RESET;
    end else if (cfg_we) begin
      width_reg <= cfg_wdata;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.take && cnt < MAXC) load_mem[cnt[AW-1:0]] <= in_value;
    if (cmd.dist_rd) load_rd <= load_mem[ptr_a[AW-1:0]];
    if (cmd.dist_put && !bucket_full) kept_mem[kc[AW-1:0]] <= x;
    if (cmd.rk_outer_rd || cmd.rk_in_rd) kept_rd <= kept_mem[kept_raddr];
    if (cmd.rk_wr) out_mem[rank[AW-1:0]] <= outer;
    if (cmd.em_rd) out_rd <= out_mem[ptr_a[AW-1:0]];
  end

  // load count, running min, drop flag, bucket fills, kept count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      run_min <= '0;
      drop    <= 1'b0;
      kc      <= '0;
      for (int i = 0; i < NUM_BUCKETS; i++) fill[i] <= '0;
    end else begin
      if (cmd.take && cnt < MAXC) begin
        cnt <= cnt + 1'b1;
        if (cnt == '0 || in_value < run_min) run_min <= in_value;
      end
      if (cmd.sort_start) begin
        drop <= 1'b0;
        kc   <= '0;
        for (int i = 0; i < NUM_BUCKETS; i++) fill[i] <= '0;
      end
      if (cmd.dist_put) begin
        if (bucket_full) begin
          drop <= 1'b1;
        end else begin
          fill[bidx] <= fill[bidx] + 1'b1;
          kc         <= kc + 1'b1;
        end
      end
      if (cmd.finish) begin
        cnt <= '0;
        kc  <= '0;
      end
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr_a <= '0;
      ptr_b <= '0;
    end else begin
      if (cmd.sort_start || cmd.ptr_clr) ptr_a <= '0;
      if (cmd.dist_put || cmd.rk_wr || cmd.em_pop) ptr_a <= ptr_a + 1'b1;
      if (cmd.rk_latch) ptr_b <= '0;
      if (cmd.rk_in_cmp) ptr_b <= ptr_b + 1'b1;
    end
  end

  // bucket index by restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.dist_init) begin
      x     <= load_rd;
      clamp <= {1'b0, diff} >= 33'(limit);
      rem   <= diff;
      dsh   <= DW'(w_eff) << (QB - 1);
      q     <= '0;
      step  <= QB'(QB - 1);
    end else if (cmd.dist_step) begin
      if (ge) rem <= rem - 32'(dsh);
      q    <= q_shift[QB-1:0];
      dsh  <= dsh >> 1;
      step <= step - 1'b1;
    end
  end

  // rank of one kept value among all kept values
  always_ff @(posedge clk) begin
    if (cmd.rk_latch) begin
      outer <= kept_rd;
      rank  <= '0;
    end else if (cmd.rk_in_cmp && less) begin
      rank <= rank + 1'b1;
    end
  end

  assign status.a_eq_cnt = ptr_a == cnt;
  assign status.a_eq_kc  = ptr_a == kc;
  assign status.b_eq_kc  = ptr_b == kc;
  assign status.div_last = step == '0;

  assign out_value   = out_rd;
  assign out_last    = (ptr_a + 1'b1) == kc;
  assign out_dropped = drop;

`include "assert_macros.svh"

  `BSE_ASSERT(a_kept_le_cnt, (kc <= cnt), "kept count exceeds loaded count")
  `BSE_ASSERT(a_cnt_le_max, (cnt <= MAXC), "load count beyond buffer depth")
  `BSE_ASSERT(a_rank_range, (cmd.rk_wr |-> rank < kc), "rank outside kept range")

endmodule

// ===== hdl/bucket_sort_engine_unit.sv =====
`timescale 1ns / 1ps
// channel   dir  tdata            tlast      tuser
// s_axis    in   value[31:0]      is_last    -
// m_axis    out  sorted_value     last_out   dropped_any
// cfg       in   bucket_width[15:0] on cfg_we
// loading takes one request a cycle; the value goes into a single-port buffer.
// after the last request, every loaded value is bucketed by a serial divider,
// then the K kept values are ranked against each other (one kept-buffer read
// port), then the results are read out in order.
// rst is synchronous; bucket_width returns to 10. input stalls until the set
// is drained; output waits on m_axis_tready with the result held.

module bucket_sort_engine_unit
  import bse_pkg::*;
#(
  parameter int MAX_ITEMS       = MAX_ITEMS_DEF,
  parameter int NUM_BUCKETS     = NUM_BUCKETS_DEF,
  parameter int BUCKET_CAPACITY = BUCKET_CAP_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] value
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [31:0] sorted_value
  output logic        m_axis_tlast,
  output logic        m_axis_tuser   // [0] dropped_any
);

  cmd_t               cmd;
  status_t            status;
  logic signed [31:0] out_value;

  // sequencer
  bse_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tready (s_axis_tready),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .status        (status),
    .cmd           (cmd)
  );

  // buffers, divider, ranking
  bse_datapath #(
    .MAX_ITEMS       (MAX_ITEMS),
    .NUM_BUCKETS     (NUM_BUCKETS),
    .BUCKET_CAPACITY (BUCKET_CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_value    ($signed(s_axis_tdata)),
    .cmd         (cmd),
    .status      (status),
    .out_value   (out_value),
    .out_last    (m_axis_tlast),
    .out_dropped (m_axis_tuser)
  );

  assign m_axis_tdata = out_value;

endmodule

// ===== dv/bucket_sort_engine_unit_tb.sv =====
`timescale 1ns / 1ps

module bucket_sort_engine_unit_tb;
  import bse_pkg::*;

  localparam int NB       = NUM_BUCKETS_DEF;
  localparam int CAP      = BUCKET_CAP_DEF;
  localparam int MAXN     = MAX_ITEMS_DEF;
  localparam int IDLE_LIM = 200000;
  localparam int N_RAND   = 170;

  typedef struct {
    logic [31:0] value;
    logic        last;
    logic        dropped;
  } sorted_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;

  // local copy of the engine state
  logic signed [31:0] set_buf[MAXN];
  int                 set_len;
  logic signed [31:0] set_min;
  logic [15:0]        width_reg;

  sorted_t sorted_q[$];
  int      n_bad;
  int      idle_cycles;
  bit      stim_done;

  bucket_sort_engine_unit u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // bucket the stored set and queue the sorted output
  task automatic bucket_and_sort();
    logic signed [31:0] bkt[NB][CAP];
    int                 fill[NB];
    logic [31:0]        w;
    logic [31:0]        idx;
    logic signed [31:0] key;
    bit                 drop;
    int                 total;
    int                 j;
    sorted_t            r;
    w = (width_reg == 0) ? 32'd1 : {16'd0, width_reg};
    drop = 0;
    total = 0;
    foreach (fill[b]) fill[b] = 0;
    for (int i = 0; i < set_len; i++) begin
      idx = (set_buf[i] - set_min) / w;
      if (idx > NB - 1) idx = NB - 1;
      if (fill[idx] >= CAP) drop = 1;
      else begin
        bkt[idx][fill[idx]] = set_buf[i];
        fill[idx]++;
      end
    end
    for (int b = 0; b < NB; b++) begin
      for (int i = 1; i < fill[b]; i++) begin
        key = bkt[b][i];
        j = i;
        while (j > 0 && bkt[b][j-1] > key) begin
          bkt[b][j] = bkt[b][j-1];
          j--;
        end
        bkt[b][j] = key;
      end
      for (int k = 0; k < fill[b]; k++) begin
        r.value = bkt[b][k];
        r.last = 0;
        r.dropped = drop;
        sorted_q.push_back(r);
        total++;
      end
    end
    if (total > 0) sorted_q[sorted_q.size()-1].last = 1;
    set_len = 0;
  endtask

  // track one accepted request
  task automatic absorb(input logic signed [31:0] v, input logic is_last);
    if (set_len < MAXN) begin
      set_buf[set_len] = v;
      if (set_len == 0 || v < set_min) set_min = v;
      set_len++;
    end
    if (is_last) bucket_and_sort();
  endtask

  // drive one request and wait for it to be taken
  task automatic send(input logic [31:0] v, input logic is_last);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= v;
    s_axis_tlast  <= is_last;
    do @(posedge clk); while (!s_axis_tready);
    absorb(v, is_last);
    @(negedge clk);
  endtask

  task automatic drain_and_set_width(input logic [15:0] w);
    s_axis_tvalid <= 0;
    while (sorted_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    cfg_we    <= 1;
    cfg_wdata <= w;
    @(negedge clk);
    cfg_we    <= 0;
    width_reg = w;
  endtask

  function automatic logic [31:0] rand_value(input int mode, input logic [31:0] base);
    case (mode)
      0: return $urandom;
      1: return base + $urandom_range(0, 200);
      default: return base + $urandom_range(0, 40000);
    endcase
  endfunction

  // random sets of random sizes and spreads
  task automatic random_set(input int n);
    int          mode;
    logic [31:0] base;
    mode = $urandom_range(0, 2);
    base = $urandom;
    for (int i = 0; i < n; i++)
      send(rand_value(mode, base), i == n - 1);
  endtask

  // sink with random stalls
  initial begin
    int wait_n;
    m_axis_tready = 0;
    forever begin
      @(negedge clk);
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      repeat (wait_n) @(negedge clk);
      m_axis_tready <= 1;
      do @(posedge clk); while (!m_axis_tvalid);
      if (sorted_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result %h", m_axis_tdata);
      end else begin
        sorted_t e;
        e = sorted_q.pop_front();
        if (m_axis_tdata !== e.value || m_axis_tlast !== e.last ||
            m_axis_tuser !== e.dropped) begin
          n_bad++;
          if (n_bad <= 10)
            $display("mismatch: exp %h last %b drop %b, got %h last %b drop %b",
                     e.value, e.last, e.dropped, m_axis_tdata, m_axis_tlast,
                     m_axis_tuser);
        end
      end
      @(negedge clk);
      m_axis_tready <= 0;
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIM) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // directed table: value, last flag
  logic [31:0] dir_val[]  = '{32'h8000_0000, 32'h7fff_ffff, 32'd0, 32'd5,
                              32'hffff_fffb, 32'd42, 32'd42, 32'd7,
                              32'd3, 32'd100, 32'd1, 32'd2};
  logic        dir_last[] = '{0, 1, 1, 0, 1, 1, 0, 1, 0, 0, 0, 1};

  initial begin
    int sent;
    set_len = 0;
    set_min = 0;
    width_reg = WIDTH_RESET;
    rst = 1;
    cfg_we = 0;
    cfg_wdata = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = 0;
    s_axis_tlast = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // extremes and one-value sets at reset width
    foreach (dir_val[i]) send(dir_val[i], dir_last[i]);
    // single value result is known at a glance
    drain_and_set_width(16'hffff);
    send(32'd123, 1);
    // extreme spread forces clamping into the top bucket and drops
    drain_and_set_width(16'd1);
    for (int i = 0; i < 20; i++) send(i == 0 ? 32'h8000_0000 : 32'h7fff_ff00 + i, i == 19);
    // overflowing buffer: extra values ignored, last still sorts
    drain_and_set_width(16'd0);
    for (int i = 0; i < MAXN + 3; i++) send(32'($urandom_range(0, 300)), i == MAXN + 2);

    // random sets, width changed between them
    sent = 0;
    while (sent < N_RAND) begin
      int n;
      case ($urandom_range(0, 4))
        0: drain_and_set_width(16'd1);
        1: drain_and_set_width(16'hffff);
        2: drain_and_set_width(16'($urandom_range(1, 500)));
        default: ;
      endcase
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 66) : $urandom_range(1, 12);
      random_set(n);
      sent += n;
    end

    s_axis_tvalid <= 0;
    while (sorted_q.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (n_bad == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
